// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker bbrq_checker.sv of this project.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bbrq_pkg.sv
// Package for the byte budget ring queue: types, codes and default sizes.
// Used by every module of the block but bbrq_slot_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bbrq_pkg;

   localparam int unsigned DEF_SLOT_DEPTH = 64;
   localparam int unsigned DEF_TAG_WIDTH  = 32;
   localparam int unsigned DEF_SIZE_WIDTH = 24;

   localparam int unsigned BYTE_W = 24;
   localparam int unsigned CNT_W  = 7;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_CLOSED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RECORD_LIMIT = 2'd0,
      CSR_BYTE_BUDGET  = 2'd1,
      CSR_SLOT_RESERVE = 2'd2,
      CSR_BYTE_RESERVE = 2'd3
   } csr_index_type;

   localparam logic [CNT_W-1:0]  RESET_RECORD_LIMIT = 7'd64;
   localparam logic [BYTE_W-1:0] RESET_BYTE_BUDGET  = 24'hFFFFFF;

   // Effective limits seen by the admission check.
   typedef struct packed {
      logic              settling;
      logic [CNT_W-1:0]  rec_cap;
      logic [CNT_W-1:0]  rec_ord;
      logic [BYTE_W-1:0] byte_cap;
      logic [BYTE_W-1:0] byte_ord;
   } limits_type;

endpackage

`default_nettype wire

// File: hw/rtl/byte_budget_ring_queue.sv
// Top level of the byte budget ring queue: request sequencer, queue state and
// result register. Depends on bbrq_pkg, bbrq_slot_ram and bbrq_limits.
`timescale 1ns / 1ps
`default_nettype none

// The byte budget ring queue is a FIFO of records (tag, byte size, control
// flag) held in a single-port-read, single-port-write slot memory. Each
// request is a push, a pop or a close and returns exactly one response that
// carries a status, the popped record (zero unless a pop succeeded) and the
// occupancy and byte total after the request. A request is accepted in the
// idle state while the slot at the read pointer is fetched; in the execute
// state, once the result register is free, the memory data is available,
// the admission check or pop is resolved, the slot is written (the new
// record on a push, zeros on a pop) and the response is loaded into the
// output register. No new request is accepted until the sequencer is back
// in idle. A waiting response does not block the next request from being
// accepted; a stalled response in the result register holds the sequencer
// in execute. After reset and after every configuration write,
// requests are stalled while the effective limits (zero limits as one,
// record limit clamped to the ring depth, reserves clamped to their limits)
// settle in their pipeline. Configuration writes are always ready and are
// meant to be issued only when no request is in flight. Slot contents are
// not cleared at reset; only a successful pop uses a slot's data, and the
// block itself does not ensure that a slot is written before it is read.
module byte_budget_ring_queue #(
   parameter int unsigned SLOT_DEPTH = bbrq_pkg::DEF_SLOT_DEPTH,
   parameter int unsigned TAG_WIDTH  = bbrq_pkg::DEF_TAG_WIDTH,
   parameter int unsigned SIZE_WIDTH = bbrq_pkg::DEF_SIZE_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [TAG_WIDTH-1:0]           req_item_tag,
   input  wire logic [SIZE_WIDTH-1:0]          req_item_bytes,
   input  wire logic                           req_is_control,

   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [TAG_WIDTH-1:0]                rsp_popped_tag,
   output logic [SIZE_WIDTH-1:0]               rsp_popped_bytes,
   output logic                                rsp_popped_control,
   output logic [bbrq_pkg::CNT_W-1:0]          rsp_occupancy,
   output logic [bbrq_pkg::BYTE_W-1:0]         rsp_bytes_held,

   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bbrq_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bbrq_pkg::BYTE_W-1:0]    csr_wdata
);
   import bbrq_pkg::*;

   localparam int unsigned PTR_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int unsigned CMP_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int unsigned DATA_W = TAG_WIDTH + SIZE_WIDTH + 1;

   // Sequencer states, one-hot.
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   limits_type limits;

   // Queue state.
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] total_ff, total_in;
   logic              closed_ff, closed_in;

   // Request held during execution.
   op_type                op_ff;
   logic [TAG_WIDTH-1:0]  tag_ff;
   logic [SIZE_WIDTH-1:0] bytes_ff;
   logic                  ctrl_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [TAG_WIDTH-1:0]  ptag_ff, ptag_in;
   logic [SIZE_WIDTH-1:0] pbytes_ff, pbytes_in;
   logic                  pctrl_ff, pctrl_in;

   // Slot memory signals.
   logic              mem_wr_en;
   logic [DATA_W-1:0] mem_wr_data;
   logic [DATA_W-1:0] mem_rd_data;
   logic [PTR_W-1:0]  mem_wr_addr;

   logic req_take;
   logic exec_go;

   logic [TAG_WIDTH-1:0]  rd_tag;
   logic [SIZE_WIDTH-1:0] rd_bytes;
   logic                  rd_ctrl;

   logic [BYTE_W:0]   push_sum;
   logic [BYTE_W:0]   pop_diff;
   logic              room_any, room_ord, admit;
   logic [CMP_W-1:0]  rd_next, wr_next, cap_ext;

   assign csr_ready = 1'b1;

   bbrq_limits #(
      .SLOT_DEPTH(SLOT_DEPTH)
   ) u_limits (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   assign req_stall = (state_ff != S_IDLE) | limits.settling;
   assign req_take  = req_valid & ~req_stall;

   // The result register is free when empty or when its content leaves now.
   assign exec_go = (state_ff == S_EXEC) & (~rsp_valid_ff | ~rsp_stall);

   bbrq_slot_ram #(
      .DEPTH  (SLOT_DEPTH),
      .DATA_W (DATA_W),
      .ADDR_W (PTR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_take),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data)
   );

   assign rd_tag   = mem_rd_data[TAG_WIDTH-1:0];
   assign rd_bytes = mem_rd_data[TAG_WIDTH +: SIZE_WIDTH];
   assign rd_ctrl  = mem_rd_data[DATA_W-1];

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= op_type'(req_operation);
         tag_ff   <= req_item_tag;
         bytes_ff <= req_item_bytes;
         ctrl_ff  <= req_is_control;
      end
   end

   // Admission: the new byte total and record count must fit both limits, and
   // for an ordinary record also what is left of them outside the reserves.
   always_comb begin
      push_sum = {1'b0, total_ff} + (BYTE_W + 1)'(bytes_ff);
      pop_diff = {1'b0, total_ff} - (BYTE_W + 1)'(rd_bytes);
      room_any = (push_sum <= {1'b0, limits.byte_cap}) & (count_ff < limits.rec_cap);
      room_ord = (push_sum <= {1'b0, limits.byte_ord}) & (count_ff < limits.rec_ord);
      admit    = room_any & (ctrl_ff | room_ord);
      cap_ext  = CMP_W'(limits.rec_cap);
      rd_next  = CMP_W'(rd_ptr_ff) + CMP_W'(1);
      wr_next  = CMP_W'(wr_ptr_ff) + CMP_W'(1);
      if (rd_next >= cap_ext) begin
         rd_next = '0;
      end
      if (wr_next >= cap_ext) begin
         wr_next = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      status_in    = status_ff;
      ptag_in      = ptag_ff;
      pbytes_in    = pbytes_ff;
      pctrl_in     = pctrl_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_ptr_ff;
      mem_wr_data  = {ctrl_ff, bytes_ff, tag_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               ptag_in      = '0;
               pbytes_in    = '0;
               pctrl_in     = 1'b0;
               case (op_ff)
                  OP_PUSH: begin
                     if (closed_ff) begin
                        status_in = ST_CLOSED;
                     end else if (!admit) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        wr_ptr_in = wr_next[PTR_W-1:0];
                        count_in  = count_ff + CNT_W'(1);
                        total_in  = push_sum[BYTE_W-1:0];
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = closed_ff ? ST_CLOSED : ST_EMPTY;
                     end else begin
                        // The popped slot is cleared so that a later read of
                        // it after a ring resize returns zeros.
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = rd_ptr_ff;
                        mem_wr_data = '0;
                        ptag_in     = rd_tag;
                        pbytes_in   = rd_bytes;
                        pctrl_in    = rd_ctrl;
                        rd_ptr_in   = rd_next[PTR_W-1:0];
                        count_in    = count_ff - CNT_W'(1);
                        total_in    = pop_diff[BYTE_W] ? '0 : pop_diff[BYTE_W-1:0];
                     end
                  end
                  OP_CLOSE: begin
                     closed_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Occupancy and byte total are sampled together with the response.
   logic [CNT_W-1:0]  occ_ff;
   logic [BYTE_W-1:0] held_ff;

   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff <= status_in;
         ptag_ff   <= ptag_in;
         pbytes_ff <= pbytes_in;
         pctrl_ff  <= pctrl_in;
         occ_ff    <= count_in;
         held_ff   <= total_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_popped_tag     = ptag_ff;
   assign rsp_popped_bytes   = pbytes_ff;
   assign rsp_popped_control = pctrl_ff;
   assign rsp_occupancy      = occ_ff;
   assign rsp_bytes_held     = held_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bbrq_slot_ram.sv
// Slot memory of the byte budget ring queue: one write port, one read port,
// registered read data. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bbrq_slot_ram #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned DATA_W = 57,
   parameter int unsigned ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bbrq_limits.sv
// Configuration registers of the byte budget ring queue and the two-stage
// pipeline that turns them into effective limits. Depends on bbrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbrq_limits #(
   parameter int unsigned SLOT_DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [bbrq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bbrq_pkg::BYTE_W-1:0]     csr_wdata,
   output bbrq_pkg::limits_type                 limits
);
   import bbrq_pkg::*;

   localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
   localparam int unsigned CAP_MAX = (SLOT_DEPTH < CNT_MAX) ? SLOT_DEPTH : CNT_MAX;
   localparam logic [CNT_W-1:0] CAP_MAX_C = CNT_W'(CAP_MAX);

   logic [CNT_W-1:0]  rec_limit_ff, slot_rsv_ff;
   logic [BYTE_W-1:0] byte_budget_ff, byte_rsv_ff;
   logic [1:0]        settle_ff, settle_in;

   logic [CNT_W-1:0]  rc_ff, rc_in, rr_ff, rr_in;
   logic [BYTE_W-1:0] bc_ff, bc_in, rb_ff, rb_in;
   logic [CNT_W-1:0]  rlim_ff, rlim_in, rc2_ff;
   logic [BYTE_W-1:0] blim_ff, blim_in, bc2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_limit_ff   <= RESET_RECORD_LIMIT;
         byte_budget_ff <= RESET_BYTE_BUDGET;
         slot_rsv_ff    <= '0;
         byte_rsv_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RECORD_LIMIT: rec_limit_ff   <= csr_wdata[CNT_W-1:0];
            CSR_BYTE_BUDGET:  byte_budget_ff <= csr_wdata;
            CSR_SLOT_RESERVE: slot_rsv_ff    <= csr_wdata[CNT_W-1:0];
            CSR_BYTE_RESERVE: byte_rsv_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Flags the limits as settling after reset or a write until the pipeline settles.
   always_comb begin
      settle_in = settle_ff;
      if (csr_write) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd2;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // Stage one: zero limits count as one, the record limit is clamped to the
   // ring depth, and each reserve is clamped to its limit.
   always_comb begin
      rc_in = (rec_limit_ff == '0) ? CNT_W'(1) : rec_limit_ff;
      if (rc_in > CAP_MAX_C) begin
         rc_in = CAP_MAX_C;
      end
      rr_in = (slot_rsv_ff > rc_in) ? rc_in : slot_rsv_ff;
      bc_in = (byte_budget_ff == '0) ? BYTE_W'(1) : byte_budget_ff;
      rb_in = (byte_rsv_ff > bc_in) ? bc_in : byte_rsv_ff;
   end

   // Stage two: what is left for ordinary records.
   assign rlim_in = rc_ff - rr_ff;
   assign blim_in = bc_ff - rb_ff;

   always_ff @(posedge clock) begin
      rc_ff   <= rc_in;
      rr_ff   <= rr_in;
      bc_ff   <= bc_in;
      rb_ff   <= rb_in;
      rc2_ff  <= rc_ff;
      bc2_ff  <= bc_ff;
      rlim_ff <= rlim_in;
      blim_ff <= blim_in;
   end

   assign limits.settling = (settle_ff != 2'd0);
   assign limits.rec_cap  = rc2_ff;
   assign limits.rec_ord  = rlim_ff;
   assign limits.byte_cap = bc2_ff;
   assign limits.byte_ord = blim_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bbrq_checker.sv
// Port-level checker for the byte budget ring queue and its bind statement.
// Depends on bbrq_pkg, assert_macros.svh and byte_budget_ring_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbrq_checker #(
   parameter int unsigned SLOT_DEPTH = bbrq_pkg::DEF_SLOT_DEPTH,
   parameter int unsigned TAG_WIDTH  = bbrq_pkg::DEF_TAG_WIDTH,
   parameter int unsigned SIZE_WIDTH = bbrq_pkg::DEF_SIZE_WIDTH
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [1:0]                 rsp_status,
   input wire logic [TAG_WIDTH-1:0]       rsp_popped_tag,
   input wire logic [SIZE_WIDTH-1:0]      rsp_popped_bytes,
   input wire logic                       rsp_popped_control,
   input wire logic [bbrq_pkg::CNT_W-1:0] rsp_occupancy,
   input wire logic [bbrq_pkg::BYTE_W-1:0] rsp_bytes_held
);
   import bbrq_pkg::*;

   localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(SLOT_DEPTH > 127 ? 127 : SLOT_DEPTH);

   // A stalled response stays valid and keeps its status, popped tag, occupancy and byte total.
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_popped_tag) && $stable(rsp_occupancy) && $stable(rsp_bytes_held), "stalled response changed")

   // A refused or empty request never returns record contents.
   `ASSERT_SAME_CYCLE(a_no_payload, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_popped_tag == '0 && rsp_popped_bytes == '0 && rsp_popped_control == 1'b0, "record data on failed request")

   // An empty report means no records are queued.
   `ASSERT_SAME_CYCLE(a_empty_occ, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_occupancy == '0, "empty status with records queued")

   // Occupancy never exceeds the ring depth.
   `ASSERT_SAME_CYCLE(a_occ_bound, clock, reset, rsp_valid, {1'b0, rsp_occupancy} <= DEPTH_C, "occupancy above ring depth")

endmodule

bind byte_budget_ring_queue bbrq_checker #(
   .SLOT_DEPTH (SLOT_DEPTH),
   .TAG_WIDTH  (TAG_WIDTH),
   .SIZE_WIDTH (SIZE_WIDTH)
) u_bbrq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_popped_tag     (rsp_popped_tag),
   .rsp_popped_bytes   (rsp_popped_bytes),
   .rsp_popped_control (rsp_popped_control),
   .rsp_occupancy      (rsp_occupancy),
   .rsp_bytes_held     (rsp_bytes_held)
);

`default_nettype wire

// File: tb/ring_queue_checker.sv
`timescale 1ns / 1ps
// Response checker for the byte budget ring queue: keeps its own copy of the
// ring, the limits and the close flag, predicts one response per request and
// compares. Depends on bbrq_pkg only.
module ring_queue_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic [31:0]                    req_item_tag,
   input  logic [23:0]                    req_item_bytes,
   input  logic                           req_is_control,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic [31:0]                    rsp_popped_tag,
   input  logic [23:0]                    rsp_popped_bytes,
   input  logic                           rsp_popped_control,
   input  logic [bbrq_pkg::CNT_W-1:0]     rsp_occupancy,
   input  logic [bbrq_pkg::BYTE_W-1:0]    rsp_bytes_held,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bbrq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbrq_pkg::BYTE_W-1:0]    csr_wdata,
   output int                             error_count,
   output int                             pending_count
);
   import bbrq_pkg::*;

   localparam int unsigned DEPTH  = DEF_SLOT_DEPTH;
   localparam int unsigned TAG_W  = DEF_TAG_WIDTH;
   localparam int unsigned SIZE_W = DEF_SIZE_WIDTH;

   typedef struct packed {
      status_type        status;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] bytes;
      logic              ctrl;
      logic [CNT_W-1:0]  occupancy;
      logic [BYTE_W-1:0] held;
   } queue_response_type;

   logic [TAG_W-1:0]   slot_tag   [DEPTH];
   logic [SIZE_W-1:0]  slot_bytes [DEPTH];
   logic               slot_ctrl  [DEPTH];
   int unsigned        rd_ptr;
   int unsigned        wr_ptr;
   int unsigned        rec_count;
   logic [BYTE_W-1:0]  held_bytes;
   logic               queue_closed;
   logic [CNT_W-1:0]   lim_records;
   logic [BYTE_W-1:0]  lim_bytes;
   logic [CNT_W-1:0]   res_records;
   logic [BYTE_W-1:0]  res_bytes;
   queue_response_type awaited_responses[$];
   int                 fail_tally = 0;

   assign error_count = fail_tally;

   function automatic int unsigned record_cap();
      int unsigned cap;
      cap = (lim_records == 0) ? 1 : lim_records;
      return (cap > DEPTH) ? DEPTH : cap;
   endfunction

   function automatic int unsigned byte_cap();
      return (lim_bytes == 0) ? 1 : lim_bytes;
   endfunction

   function automatic int unsigned next_slot(int unsigned p, int unsigned cap);
      return (p + 1 >= cap) ? 0 : p + 1;
   endfunction

   // Control records may use the whole of both limits; ordinary records
   // must fit outside both reserves.
   function automatic bit has_room(logic [SIZE_W-1:0] size, logic ctrl);
      int unsigned rcap, bcap, rres, bres, rord, bord;
      rcap = record_cap();
      bcap = byte_cap();
      rres = (res_records > rcap) ? rcap : res_records;
      bres = (res_bytes > bcap) ? bcap : res_bytes;
      if (held_bytes > bcap || size > bcap - held_bytes) return 1'b0;
      if (rec_count >= rcap) return 1'b0;
      if (ctrl) return 1'b1;
      rord = rcap - rres;
      bord = bcap - bres;
      if (rec_count >= rord || size > bord) return 1'b0;
      return held_bytes <= bord - size;
   endfunction

   function automatic queue_response_type predict_response(logic [1:0] op,
         logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] size, logic ctrl);
      queue_response_type r;
      int unsigned cap, slot;
      cap = record_cap();
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (queue_closed) begin
               r.status = ST_CLOSED;
            end else if (!has_room(size, ctrl)) begin
               r.status = ST_FULL;
            end else begin
               slot = wr_ptr % DEPTH;
               slot_tag[slot] = tag;
               slot_bytes[slot] = size;
               slot_ctrl[slot] = ctrl;
               wr_ptr = next_slot(slot, cap);
               rec_count++;
               held_bytes = held_bytes + size;
            end
         end
         OP_POP: begin
            if (rec_count == 0) begin
               r.status = queue_closed ? ST_CLOSED : ST_EMPTY;
            end else begin
               slot = rd_ptr % DEPTH;
               r.tag = slot_tag[slot];
               r.bytes = slot_bytes[slot];
               r.ctrl = slot_ctrl[slot];
               slot_tag[slot] = '0;
               slot_bytes[slot] = '0;
               slot_ctrl[slot] = 1'b0;
               rd_ptr = next_slot(slot, cap);
               rec_count--;
               held_bytes = (r.bytes > held_bytes) ? '0 : held_bytes - r.bytes;
            end
         end
         OP_CLOSE: queue_closed = 1'b1;
         default: ;
      endcase
      r.occupancy = rec_count[CNT_W-1:0];
      r.held = held_bytes;
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      queue_response_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            slot_tag[i] = '0;
            slot_bytes[i] = '0;
            slot_ctrl[i] = 1'b0;
         end
         rd_ptr = 0;
         wr_ptr = 0;
         rec_count = 0;
         held_bytes = '0;
         queue_closed = 1'b0;
         lim_records = RESET_RECORD_LIMIT;
         lim_bytes = RESET_BYTE_BUDGET;
         res_records = '0;
         res_bytes = '0;
         awaited_responses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RECORD_LIMIT: lim_records = csr_wdata[CNT_W-1:0];
               CSR_BYTE_BUDGET:  lim_bytes = csr_wdata;
               CSR_SLOT_RESERVE: res_records = csr_wdata[CNT_W-1:0];
               CSR_BYTE_RESERVE: res_bytes = csr_wdata;
               default: ;
            endcase
         end
         // A response always trails its request, so it is matched before
         // the request of the same cycle is added.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response with no request outstanding");
               fail_tally++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("popped_tag", want.tag, rsp_popped_tag);
               check_field("popped_bytes", want.bytes, rsp_popped_bytes);
               check_field("popped_control", want.ctrl, rsp_popped_control);
               check_field("occupancy", want.occupancy, rsp_occupancy);
               check_field("bytes_held", want.held, rsp_bytes_held);
            end
         end
         if (req_valid && !req_stall)
            awaited_responses.push_back(predict_response(req_operation, req_item_tag,
                                                         req_item_bytes, req_is_control));
      end
      pending_count <= awaited_responses.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the byte budget ring queue testbench: clock, reset, request and
// limit stimulus, response stalls and the verdict. Depends on bbrq_pkg,
// ring_queue_checker and the block itself.
module testbench;
   import bbrq_pkg::*;

   // Operation code that the block must treat as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles without any handshake before the run is declared hung.
   localparam int STUCK_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_operation = OP_PUSH;
   logic [31:0]          req_item_tag = '0;
   logic [23:0]          req_item_bytes = '0;
   logic                 req_is_control = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [31:0]          rsp_popped_tag;
   logic [23:0]          rsp_popped_bytes;
   logic                 rsp_popped_control;
   logic [CNT_W-1:0]     rsp_occupancy;
   logic [BYTE_W-1:0]    rsp_bytes_held;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RECORD_LIMIT;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   int                   mismatch_count;
   int                   pending_count;
   // When low, neither side idles or stalls at random.
   logic                 jitter_on = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   byte_budget_ring_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_item_tag       (req_item_tag),
      .req_item_bytes     (req_item_bytes),
      .req_is_control     (req_is_control),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_popped_tag     (rsp_popped_tag),
      .rsp_popped_bytes   (rsp_popped_bytes),
      .rsp_popped_control (rsp_popped_control),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_bytes_held     (rsp_bytes_held),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   ring_queue_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_item_tag       (req_item_tag),
      .req_item_bytes     (req_item_bytes),
      .req_is_control     (req_is_control),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_popped_tag     (rsp_popped_tag),
      .rsp_popped_bytes   (rsp_popped_bytes),
      .rsp_popped_control (rsp_popped_control),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_bytes_held     (rsp_bytes_held),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .error_count        (mismatch_count),
      .pending_count      (pending_count)
   );

   // The response side stalls at random, with a chance of six in a hundred, while
   // jitter is enabled, so stalls land on every phase of a request.
   always @(posedge clock) begin
      rsp_stall <= jitter_on && ($urandom_range(99) < 6);
   end

   // Hands one request to the block and usually returns in the time step of
   // the edge that accepted it. The request stays valid and unchanged while
   // the block stalls. Now and then the sender drops valid and idles before
   // returning; otherwise valid simply stays high into the next request.
   task automatic issue(logic [1:0] op, logic [31:0] tag, logic [23:0] size, logic ctrl);
      req_valid <= 1'b1;
      req_operation <= op;
      req_item_tag <= tag;
      req_item_bytes <= size;
      req_is_control <= ctrl;
      do @(posedge clock); while (req_stall);
      if (jitter_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding request has been
   // answered. The checker's count is registered, so the task always waits
   // for a clock edge before looking at it.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Writes all four limit registers back to back; the write channel stays
   // valid across the sequence. Only called with no request in flight.
   task automatic load_limits(logic [23:0] rec_limit, logic [23:0] byte_budget,
                              logic [23:0] slot_reserve, logic [23:0] byte_reserve);
      csr_index_type order [4] = '{CSR_RECORD_LIMIT, CSR_BYTE_BUDGET,
                                   CSR_SLOT_RESERVE, CSR_BYTE_RESERVE};
      logic [23:0]   value [4];
      value = '{rec_limit, byte_budget, slot_reserve, byte_reserve};
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= order[i];
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly sizes that suit the current limits, with the extremes and
   // arbitrary 24-bit values mixed in so every size bit toggles.
   function automatic logic [23:0] pick_size(int unsigned ceiling);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 4) return 24'hFFFFFF;
      if (roll < 8) return 24'h000000;
      if (roll < 12) return 24'($urandom);
      return 24'($urandom_range(ceiling));
   endfunction

   // Random traffic in bursts that lean either toward pushing or toward
   // popping, so the queue repeatedly runs into both its limits and empties.
   task automatic run_phase(int count, int unsigned ceiling, bit pause_midway);
      int          sent;
      int          burst;
      int unsigned roll;
      int unsigned push_share;
      logic [1:0]  op;
      sent = 0;
      while (sent < count) begin
         push_share = $urandom_range(1) ? 75 : 30;
         burst = $urandom_range(24, 1);
         repeat (burst) begin
            roll = $urandom_range(99);
            if (roll < 4) op = OP_UNUSED;
            else if (roll < push_share) op = OP_PUSH;
            else op = OP_POP;
            issue(op, $urandom, pick_size(ceiling), 1'($urandom_range(1)));
            sent++;
         end
         // Let the pipeline run completely dry once in the middle.
         if (pause_midway && sent >= count / 2) begin
            wait_for_drain();
            pause_midway = 1'b0;
         end
      end
   endtask

   // Watchdog: the run is hung if no request, response or register write
   // completes before the idle counter reaches STUCK_LIMIT.
   initial begin
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset limits: empty pop, the unused code,
      // tag and size extremes, a record that uses the whole byte budget,
      // a refusal on bytes, a zero-byte control record that still fits,
      // and popping everything back in order.
      issue(OP_POP, 32'h0, 24'h0, 1'b0);
      issue(OP_UNUSED, 32'h5A5A5A5A, 24'h123456, 1'b1);
      issue(OP_PUSH, 32'h00000000, 24'h000000, 1'b0);
      issue(OP_PUSH, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
      issue(OP_PUSH, 32'hA5A5A5A5, 24'h000001, 1'b0);
      issue(OP_PUSH, 32'h80000001, 24'h800000, 1'b1);
      issue(OP_PUSH, 32'h7FFFFFFE, 24'h000000, 1'b1);
      issue(OP_POP, 32'h0, 24'h0, 1'b0);
      issue(OP_POP, 32'h0, 24'h0, 1'b0);
      issue(OP_POP, 32'h0, 24'h0, 1'b0);
      issue(OP_POP, 32'h0, 24'h0, 1'b0);
      issue(OP_PUSH, 32'h12345678, 24'h7FFFFF, 1'b0);
      issue(OP_POP, 32'h0, 24'h0, 1'b0);

      // Fill the whole ring until it refuses on the record count, then
      // empty it. After this every slot has been written at least once,
      // so later limit changes cannot expose a slot that was never written.
      repeat (66) issue(OP_PUSH, $urandom, 24'($urandom_range(65535)),
                        1'($urandom_range(1)));
      repeat (66) issue(OP_POP, $urandom, 24'($urandom), 1'($urandom_range(1)));

      // A long stretch at the reset limits with no idling on either side,
      // including one complete drain in the middle.
      jitter_on <= 1'b0;
      run_phase(250, 65535, 1'b1);
      jitter_on <= 1'b1;

      // Small ring with both reserves in force. The queue may still hold
      // more records than the new limit allows, so it must refuse pushes
      // until enough have been popped.
      wait_for_drain();
      load_limits(24'd8, 24'd1000, 24'd2, 24'd300);
      run_phase(220, 400, 1'b0);

      // Smallest legal limits: one record, one byte.
      wait_for_drain();
      load_limits(24'd1, 24'd1, 24'd0, 24'd0);
      run_phase(180, 2, 1'b0);

      // Zero limits act as one; reserves far above the limits are clamped.
      wait_for_drain();
      load_limits(24'd0, 24'd0, 24'd127, 24'hFFFFFF);
      run_phase(150, 2, 1'b0);

      // Record limit above the ring depth is clamped; the reserves cover
      // everything, so only control records get in.
      wait_for_drain();
      load_limits(24'd127, 24'hFFFFFF, 24'd64, 24'hFFFFFF);
      run_phase(220, 65535, 1'b0);

      // Full ring depth with a tight byte budget and partial reserves.
      wait_for_drain();
      load_limits(24'd64, 24'd5000, 24'd10, 24'd2000);
      run_phase(250, 600, 1'b0);

      // Short ring that wraps often, large byte budget.
      wait_for_drain();
      load_limits(24'd3, 24'd100000, 24'd1, 24'd0);
      run_phase(200, 60000, 1'b0);

      // Closing comes last since nothing reopens the queue. Queue a few
      // control records, close, then check that pushes are refused, that
      // the queued records still come out, that an empty closed queue
      // reports closed, and that a second close is harmless.
      repeat (4) issue(OP_PUSH, $urandom, 24'($urandom_range(200)), 1'b1);
      issue(OP_CLOSE, $urandom, 24'($urandom), 1'b0);
      issue(OP_PUSH, $urandom, 24'h000000, 1'b1);
      issue(OP_PUSH, $urandom, 24'h000010, 1'b0);
      repeat (8) issue(OP_POP, $urandom, 24'($urandom), 1'b0);
      issue(OP_CLOSE, $urandom, 24'($urandom), 1'b1);
      issue(OP_UNUSED, $urandom, 24'($urandom), 1'b0);
      repeat (30) issue(2'($urandom_range(3)), $urandom, pick_size(1000),
                        1'($urandom_range(1)));

      wait_for_drain();
      // Wait on with no requests to catch any response the block sends unasked.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
